FILE: hw/rtl/ftq_pkg.sv
// ----------------------------------------------------------------------------
// ftq_pkg
// Shared types and constants of the token quoter: request and result
// payloads, and the queue entry that carries one request's result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package ftq_pkg;

  // Most result bytes that one request can produce.
  localparam int unsigned MaxResults = 7;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // Default number of entries between the front and the back.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_t;

  // All results of one request. A marker entry holds the empty end marker.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       marker;
    logic                       last;
  } ftq_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ftq_front.sv
// ----------------------------------------------------------------------------
// ftq_front
// Accepts one text byte per cycle unless the queue is full, matches it with
// the held prefix bytes against the whitespace set and builds all result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ftq_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ftq_pkg::in_t       in_req,
  input  wire logic               q_full,
  output logic                    push,
  output ftq_pkg::ftq_entry_t     entry
);
  import ftq_pkg::*;

  localparam logic [2:0] ClsNone = 3'd0;
  localparam logic [2:0] ClsHold = 3'd4;

  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrSpace = 8'h20;

  logic [1:0][7:0] held_bytes;
  logic [1:0][7:0] held_bytes_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic            inside_token;
  logic            inside_token_next;
  logic            token_seen;
  logic            token_seen_next;

  logic [2:0][7:0] pv;
  logic [1:0]      n;
  logic [1:0]      start;
  logic [1:0]      avail;
  logic            done;
  logic [7:0]      a;
  logic [7:0]      b;
  logic [7:0]      c;
  logic [2:0]      cls;
  ftq_entry_t      ent;
  logic            accept;

  function automatic logic is_ws1(input logic [7:0] x);
    return (x >= 8'h09 && x <= 8'h0D) || x == 8'h20;
  endfunction

  function automatic logic is_ws3(input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] z);
    logic r;
    r = 1'b0;
    if (x == 8'hE1) r = (y == 8'h9A) && (z == 8'h80);
    else if (x == 8'hE2 && y == 8'h80)
      r = (z >= 8'h80 && z <= 8'h8A) || z == 8'hA8 || z == 8'hA9 || z == 8'hAF;
    else if (x == 8'hE2 && y == 8'h81) r = (z == 8'h9F);
    else if (x == 8'hE3) r = (y == 8'h80) && (z == 8'h80);
    else if (x == 8'hEF) r = (y == 8'hBB) && (z == 8'hBF);
    return r;
  endfunction

  function automatic logic is_pre3(input logic [7:0] x, input logic [7:0] y);
    return (x == 8'hE1 && y == 8'h9A) || (x == 8'hE2 && (y == 8'h80 || y == 8'h81)) ||
           (x == 8'hE3 && y == 8'h80) || (x == 8'hEF && y == 8'hBB);
  endfunction

  // Whitespace length at the first byte, no match, or hold for more bytes.
  function automatic logic [2:0] classify(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] z, input logic [1:0] cnt,
                                          input logic fin);
    logic [2:0] r;
    r = ClsNone;
    if (is_ws1(x)) begin
      r = 3'd1;
    end else if (x == 8'hC2) begin
      if (cnt >= 2'd2) r = (y == 8'hA0) ? 3'd2 : ClsNone;
      else             r = fin ? ClsNone : ClsHold;
    end else if (x == 8'hE1 || x == 8'hE2 || x == 8'hE3 || x == 8'hEF) begin
      if (cnt == 2'd3)                      r = is_ws3(x, y, z) ? 3'd3 : ClsNone;
      else if (cnt == 2'd2 && !is_pre3(x, y)) r = ClsNone;
      else                                  r = fin ? ClsNone : ClsHold;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick(input logic [2:0][7:0] v, input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = v[0];
      3'd1:    r = v[1];
      3'd2:    r = v[2];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic ftq_entry_t put(input ftq_entry_t e, input logic [7:0] x);
    ftq_entry_t r;
    r = e;
    if (r.count != CountW'(MaxResults)) begin
      r.bytes[r.count[$clog2(MaxResults)-1:0]] = x;
      r.count = r.count + CountW'(1);
    end
    return r;
  endfunction

  always_comb begin
    pv = '0;
    case (held_count)
      2'd0: pv[0] = in_req.in_byte;
      2'd1: begin
        pv[0] = held_bytes[0];
        pv[1] = in_req.in_byte;
      end
      default: begin
        pv[0] = held_bytes[0];
        pv[1] = held_bytes[1];
        pv[2] = in_req.in_byte;
      end
    endcase
    n = (held_count >= 2'd2) ? 2'd3 : 2'(held_count + 2'd1);

    held_bytes_next   = held_bytes;
    held_count_next   = 2'd0;
    inside_token_next = inside_token;
    token_seen_next   = token_seen;
    ent   = '0;
    start = 2'd0;
    avail = 2'd0;
    done  = 1'b0;
    a = 8'h00;
    b = 8'h00;
    c = 8'h00;
    cls = ClsNone;

    // Each pass either consumes at least one byte or stops on a hold.
    for (int it = 0; it < 3; it++) begin
      if (!done && start < n) begin
        avail = n - start;
        a = pick(pv, {1'b0, start});
        b = pick(pv, 3'({1'b0, start} + 3'd1));
        c = pick(pv, 3'({1'b0, start} + 3'd2));
        cls = classify(a, b, c, avail, in_req.in_last);
        if (cls == ClsHold) begin
          held_bytes_next[0] = a;
          held_bytes_next[1] = b;
          held_count_next    = avail;
          done = 1'b1;
        end else if (cls != ClsNone) begin
          if (inside_token_next) begin
            ent = put(ent, ChrQuote);
            inside_token_next = 1'b0;
          end
          start = 2'(start + cls[1:0]);
        end else begin
          if (!inside_token_next) begin
            if (token_seen_next) ent = put(ent, ChrSpace);
            ent = put(ent, ChrQuote);
            inside_token_next = 1'b1;
            token_seen_next   = 1'b1;
          end
          ent = put(ent, a);
          if (a == ChrQuote) ent = put(ent, ChrQuote);
          start = 2'(start + 2'd1);
        end
      end
    end

    if (in_req.in_last) begin
      if (inside_token_next) ent = put(ent, ChrQuote);
      if (ent.count == '0) begin
        ent = put(ent, 8'h00);
        ent.marker = 1'b1;
      end
      ent.last = 1'b1;
      held_count_next   = 2'd0;
      inside_token_next = 1'b0;
      token_seen_next   = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (ent.count != '0);
  assign entry    = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      inside_token <= 1'b0;
      token_seen   <= 1'b0;
    end else if (accept) begin
      held_count   <= held_count_next;
      inside_token <= inside_token_next;
      token_seen   <= token_seen_next;
    end
  end

  // Held bytes are only read below the held count.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ftq_queue.sv
// ----------------------------------------------------------------------------
// ftq_queue
// Short queue of result entries that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ftq_queue #(
  parameter int unsigned Depth = ftq_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ftq_pkg::ftq_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output ftq_pkg::ftq_entry_t       head,
  output logic                      empty
);
  import ftq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ftq_entry_t      mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr + PtrW'(1));
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr + PtrW'(1));
      end
      if (do_push && !do_pop) count <= CntW'(count + CntW'(1));
      else if (do_pop && !do_push) count <= CntW'(count - CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ftq_back.sv
// ----------------------------------------------------------------------------
// ftq_back
// Walks the head entry of the queue and hands its result bytes out one per
// cycle through an output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ftq_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ftq_pkg::ftq_entry_t  head,
  input  wire logic                 empty,
  output logic                      pop,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output ftq_pkg::out_t             res
);
  import ftq_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxResults);

  logic [IdxW-1:0] idx;
  logic            load;
  logic            at_end;

  assign load   = !res_valid || !res_stall;
  assign at_end = (CountW'(idx) == CountW'(head.count - CountW'(1)));
  assign pop    = load && !empty && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      res_valid <= !empty;
      if (!empty) begin
        idx <= at_end ? '0 : IdxW'(idx + IdxW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      res.out_byte  <= head.bytes[idx];
      res.out_valid <= !head.marker;
      res.out_last  <= head.last && at_end;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fulltext_token_quoter.sv
// A result passes through the queue memory and the back-stage output register.
// Throughput: one request per cycle while the queue has room; the back stage
// emits one result byte per cycle unless stalled, and pops each entry at its last byte.
// Reset clears the held count, token flags, queue pointers and output valid.
// Held prefix bytes and payload registers are not reset.
// ----------------------------------------------------------------------------
// fulltext_token_quoter
// Splits a UTF-8 byte stream on whitespace and writes each token in double
// quotes, separated by single spaces, with interior quotes doubled.
// ----------------------------------------------------------------------------
`default_nettype none

module fulltext_token_quoter #(
  parameter int unsigned QueueDepth = ftq_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ftq_pkg::in_t   in_req,
  output logic                res_valid,
  input  wire logic           res_stall,
  output ftq_pkg::out_t       res
);
  import ftq_pkg::*;

  logic       push;
  ftq_entry_t push_entry;
  logic       q_full;
  logic       pop;
  ftq_entry_t head;
  logic       q_empty;

  ftq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  ftq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  ftq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the token quoter. A driver feeds byte requests from
// a queue; a predictor tracks the held prefix bytes and token flags and builds
// the expected quoted bytes. A monitor checks every result against them while
// both sides idle and stall in changing phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ftq_pkg::*;

  localparam int HoldMatch  = 4;
  localparam int IdleLimit  = 1000;
  localparam int RandItems  = 250;
  localparam int PhaseLen   = 32;
  localparam int TailCycles = 16;
  localparam int ReportMax  = 10;

  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] SpaceChar = 8'h20;

  typedef enum int { PhaseFree, PhaseSendGap, PhaseRecvStall, PhaseBoth } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res;

  fulltext_token_quoter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_t        req_q[$];
  out_t       quoted_q[$];
  out_t       burst_q[$];
  logic [7:0] text_q[$];

  // Predictor state.
  logic [7:0] held_b[2];
  int         held_n = 0;
  bit         in_token = 0;
  bit         seen_token = 0;

  int sent_n = 0;
  int errors = 0;
  int idle_cycles = 0;

  wire in_fire  = in_valid && !in_stall;
  wire res_fire = res_valid && !res_stall;

  function automatic phase_t cur_phase();
    return phase_t'((sent_n / PhaseLen) % 4);
  endfunction

  function automatic int send_gap_pct();
    case (cur_phase())
      PhaseSendGap: return 50;
      PhaseBoth:    return 31;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (cur_phase())
      PhaseRecvStall: return 50;
      PhaseBoth:      return 31;
      default:        return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic bit is_space_byte(logic [7:0] b);
    return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
  endfunction

  function automatic bit is_space_triple(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    if (a == 8'hE1) return b == 8'h9A && c == 8'h80;
    if (a == 8'hE2 && b == 8'h80)
      return (c >= 8'h80 && c <= 8'h8A) || c == 8'hA8 || c == 8'hA9 || c == 8'hAF;
    if (a == 8'hE2 && b == 8'h81) return c == 8'h9F;
    if (a == 8'hE3) return b == 8'h80 && c == 8'h80;
    if (a == 8'hEF) return b == 8'hBB && c == 8'hBF;
    return 0;
  endfunction

  function automatic bit is_triple_prefix(logic [7:0] a, logic [7:0] b);
    return (a == 8'hE1 && b == 8'h9A) || (a == 8'hE2 && (b == 8'h80 || b == 8'h81)) ||
           (a == 8'hE3 && b == 8'h80) || (a == 8'hEF && b == 8'hBB);
  endfunction

  // Length of the whitespace sequence at a, 0 for none, HoldMatch while the
  // bytes seen so far are only the start of one.
  function automatic int space_match(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                     int n, bit at_end);
    if (is_space_byte(a)) return 1;
    if (a == 8'hC2) begin
      if (n >= 2) return (b == 8'hA0) ? 2 : 0;
      return at_end ? 0 : HoldMatch;
    end
    if (a == 8'hE1 || a == 8'hE2 || a == 8'hE3 || a == 8'hEF) begin
      if (n >= 3) return is_space_triple(a, b, c) ? 3 : 0;
      if (n == 2 && !is_triple_prefix(a, b)) return 0;
      return at_end ? 0 : HoldMatch;
    end
    return 0;
  endfunction

  task automatic put_result(logic [7:0] b, bit v);
    out_t o;
    if (burst_q.size() >= MaxResults) return;
    o.out_byte  = b;
    o.out_valid = v;
    o.out_last  = 1'b0;
    burst_q.push_back(o);
  endtask

  task automatic put_token_byte(logic [7:0] b);
    if (!in_token) begin
      if (seen_token) put_result(SpaceChar, 1'b1);
      put_result(QuoteChar, 1'b1);
      in_token   = 1;
      seen_token = 1;
    end
    put_result(b, 1'b1);
    if (b == QuoteChar) put_result(QuoteChar, 1'b1);
  endtask

  task automatic predict_quoted(in_t r);
    logic [7:0] p[5];
    int   n;
    int   start;
    int   hit;
    int   j;
    bit   at_end;
    out_t o;
    p      = '{default: 8'h00};
    n      = 0;
    start  = 0;
    at_end = r.in_last;
    burst_q.delete();
    for (int i = 0; i < held_n; i++) begin
      p[n] = held_b[i];
      n++;
    end
    p[n] = r.in_byte;
    n++;
    held_n = 0;
    while (start < n) begin
      hit = space_match(p[start], p[start+1], p[start+2], n - start, at_end);
      if (hit == HoldMatch) begin
        j = 0;
        while (start < n && j < 2) begin
          held_b[j] = p[start];
          j++;
          start++;
        end
        held_n = j;
        break;
      end
      if (hit > 0) begin
        if (in_token) begin
          put_result(QuoteChar, 1'b1);
          in_token = 0;
        end
        start += hit;
      end else begin
        put_token_byte(p[start]);
        start++;
      end
    end
    if (at_end) begin
      if (in_token) put_result(QuoteChar, 1'b1);
      if (burst_q.size() == 0) put_result(8'h00, 1'b0);
      o = burst_q[$];
      o.out_last = 1'b1;
      burst_q[$] = o;
      held_n     = 0;
      in_token   = 0;
      seen_token = 0;
    end
    foreach (burst_q[m]) quoted_q.push_back(burst_q[m]);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic queue_message();
    in_t r;
    foreach (text_q[i]) begin
      r.in_byte = text_q[i];
      r.in_last = (i == text_q.size() - 1);
      req_q.push_back(r);
    end
    text_q.delete();
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] proper_second(logic [7:0] lead);
    case (lead)
      8'hE1:   return 8'h9A;
      8'hE2:   return $urandom_range(0, 1) ? 8'h80 : 8'h81;
      8'hEF:   return 8'hBB;
      default: return 8'h80;
    endcase
  endfunction

  task automatic add_space_seq();
    case ($urandom_range(0, 8))
      0: text_q = {text_q, 8'hC2, 8'hA0};
      1: text_q = {text_q, 8'hE1, 8'h9A, 8'h80};
      2: text_q = {text_q, 8'hE2, 8'h80, 8'(8'h80 + $urandom_range(0, 10))};
      3: text_q = {text_q, 8'hE2, 8'h80, 8'hA8};
      4: text_q = {text_q, 8'hE2, 8'h80, 8'hA9};
      5: text_q = {text_q, 8'hE2, 8'h80, 8'hAF};
      6: text_q = {text_q, 8'hE2, 8'h81, 8'h9F};
      7: text_q = {text_q, 8'hE3, 8'h80, 8'h80};
      default: text_q = {text_q, 8'hEF, 8'hBB, 8'hBF};
    endcase
  endtask

  // A prefix of a multi-byte space that goes wrong, or is cut by the message end.
  task automatic add_broken_seq();
    logic [7:0] lead;
    case ($urandom_range(0, 4))
      0:       lead = 8'hC2;
      1:       lead = 8'hE1;
      2:       lead = 8'hE2;
      3:       lead = 8'hE3;
      default: lead = 8'hEF;
    endcase
    text_q.push_back(lead);
    if (lead != 8'hC2 && $urandom_range(0, 1)) text_q.push_back(proper_second(lead));
    if ($urandom_range(0, 3) != 0) text_q.push_back(rand_byte());
  endtask

  task automatic add_segment();
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            1:       text_q.push_back(QuoteChar);
            2:       text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
            default: text_q.push_back(rand_byte());
          endcase
        end
      end
      4: begin
        if ($urandom_range(0, 5) == 0) text_q.push_back(SpaceChar);
        else text_q.push_back(8'($urandom_range(8'h09, 8'h0D)));
      end
      5, 6, 8: add_space_seq();
      7:       add_broken_seq();
      default: text_q.push_back(rand_byte());
    endcase
  endtask

  task automatic queue_directed();
    text_q = {8'h41};
    queue_message();
    // Whitespace only.
    text_q = {8'h20};
    queue_message();
    // Doubled quote, then trailing whitespace after the token is closed.
    text_q = {QuoteChar, 8'h0A, 8'hFF, 8'h20, 8'h09};
    queue_message();
    // Leading two-byte space, a failed prefix, and a prefix cut by the end.
    text_q = {8'hC2, 8'hA0, 8'h61, 8'hC2, 8'h62, 8'hC2};
    queue_message();
    text_q = {8'hE3, 8'h80, 8'h80, 8'h78, 8'hE2, 8'h80, QuoteChar};
    queue_message();
    text_q = {8'h00, 8'hE2};
    queue_message();
  endtask

  task automatic queue_random();
    int count;
    int segs;
    count = 0;
    while (count < RandItems) begin
      if ($urandom_range(0, 9) == 0) begin
        text_q.push_back(rand_byte());
      end else begin
        segs = $urandom_range(1, 6);
        repeat (segs) add_segment();
      end
      count += text_q.size();
      queue_message();
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        predict_quoted(in_req);
        sent_n <= sent_n + 1;
      end
      // A stalled request stays on the bus unchanged.
      if (!in_valid || in_fire) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          in_req   <= req_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  out_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_fire) begin
        if (quoted_q.size() == 0) begin
          errors++;
          if (errors <= ReportMax)
            $display("unexpected result: byte %h valid %b last %b",
                     res.out_byte, res.out_valid, res.out_last);
        end else begin
          want = quoted_q.pop_front();
          if (res.out_byte !== want.out_byte || res.out_valid !== want.out_valid ||
              res.out_last !== want.out_last) begin
            errors++;
            if (errors <= ReportMax)
              $display("mismatch: expected byte %h valid %b last %b, got byte %h valid %b last %b",
                       want.out_byte, want.out_valid, want.out_last,
                       res.out_byte, res.out_valid, res.out_last);
          end
        end
      end
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || in_fire || res_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("fulltext_token_quoter verification failed");
        $finish;
      end
    end
  end

  initial begin
    queue_directed();
    queue_random();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (quoted_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (quoted_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("fulltext_token_quoter verification clean");
    end else begin
      $display("fulltext_token_quoter verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ftq_pkg.sv
hw/rtl/ftq_front.sv
hw/rtl/ftq_queue.sv
hw/rtl/ftq_back.sv
hw/rtl/fulltext_token_quoter.sv
test/tb.sv
